// ===== sv/ksd_pkg.sv =====
// Shared types, codes and keymap ROM for the keyboard scancode decoder.
`default_nettype none

package ksd_pkg;

    localparam int SCANCODE_W = 8;
    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int TDATA_W    = 16;
    localparam int TUSER_W    = 3;

    localparam logic [1:0] KEY_IGNORE = 2'd0;
    localparam logic [1:0] KEY_CHAR   = 2'd1;
    localparam logic [1:0] KEY_MOD    = 2'd2;

    localparam logic [1:0] MOD_SHIFT = 2'd0;
    localparam logic [1:0] MOD_CTRL  = 2'd1;
    localparam logic [1:0] MOD_META  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    localparam logic [CHAR_W-1:0] META_BIT  = 8'h80;
    localparam logic [CHAR_W-1:0] CTRL_MASK = 8'h1F;

    typedef struct packed {
        logic [1:0]        key_type;
        logic [CHAR_W-1:0] plain;
        logic [CHAR_W-1:0] upper;
    } key_entry_t;

    typedef struct packed {
        logic meta;
        logic ctrl;
        logic shift;
    } flags_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] character;
        logic [KIND_W-1:0] kind;
        flags_t            flags;
    } result_t;

    function automatic key_entry_t keymap_lookup(input logic [6:0] key);
        key_entry_t entry;
        entry = '{KEY_IGNORE, 8'h00, 8'h00};
        case (key)
            7'h09: entry = '{KEY_CHAR, 8'h09, 8'h09};
            7'h0A: entry = '{KEY_MOD, {6'd0, MOD_CTRL}, {6'd0, MOD_CTRL}};
            7'h0C: entry = '{KEY_MOD, {6'd0, MOD_SHIFT}, {6'd0, MOD_SHIFT}};
            7'h0D: entry = '{KEY_MOD, {6'd0, MOD_SHIFT}, {6'd0, MOD_SHIFT}};
            7'h0F: entry = '{KEY_MOD, {6'd0, MOD_META}, {6'd0, MOD_META}};
            7'h10: entry = '{KEY_CHAR, 8'h1B, 8'h1B};
            7'h11: entry = '{KEY_CHAR, 8'h08, 8'h08};
            7'h12: entry = '{KEY_CHAR, 8'h0D, 8'h0D};
            7'h14: entry = '{KEY_CHAR, 8'h20, 8'h20};
            7'h15: entry = '{KEY_CHAR, 8'h7F, 8'h7F};
            7'h22: entry = '{KEY_CHAR, 8'h31, 8'h21};
            7'h23: entry = '{KEY_CHAR, 8'h32, 8'h22};
            7'h24: entry = '{KEY_CHAR, 8'h33, 8'h23};
            7'h25: entry = '{KEY_CHAR, 8'h34, 8'h24};
            7'h26: entry = '{KEY_CHAR, 8'h35, 8'h25};
            7'h27: entry = '{KEY_CHAR, 8'h36, 8'h26};
            7'h28: entry = '{KEY_CHAR, 8'h37, 8'h27};
            7'h29: entry = '{KEY_CHAR, 8'h38, 8'h28};
            7'h2A: entry = '{KEY_CHAR, 8'h39, 8'h29};
            7'h2B: entry = '{KEY_CHAR, 8'h30, 8'h30};
            7'h2C: entry = '{KEY_CHAR, 8'h2D, 8'h3D};
            7'h2D: entry = '{KEY_CHAR, 8'h5E, 8'h7E};
            7'h2E: entry = '{KEY_CHAR, 8'h5C, 8'h7C};
            7'h32: entry = '{KEY_CHAR, 8'h71, 8'h51};
            7'h33: entry = '{KEY_CHAR, 8'h77, 8'h57};
            7'h34: entry = '{KEY_CHAR, 8'h65, 8'h45};
            7'h35: entry = '{KEY_CHAR, 8'h72, 8'h52};
            7'h36: entry = '{KEY_CHAR, 8'h74, 8'h54};
            7'h37: entry = '{KEY_CHAR, 8'h79, 8'h59};
            7'h38: entry = '{KEY_CHAR, 8'h75, 8'h55};
            7'h39: entry = '{KEY_CHAR, 8'h69, 8'h49};
            7'h3A: entry = '{KEY_CHAR, 8'h6F, 8'h4F};
            7'h3B: entry = '{KEY_CHAR, 8'h70, 8'h50};
            7'h3C: entry = '{KEY_CHAR, 8'h40, 8'h60};
            7'h3D: entry = '{KEY_CHAR, 8'h5B, 8'h7B};
            7'h42: entry = '{KEY_CHAR, 8'h61, 8'h41};
            7'h43: entry = '{KEY_CHAR, 8'h73, 8'h53};
            7'h44: entry = '{KEY_CHAR, 8'h64, 8'h44};
            7'h45: entry = '{KEY_CHAR, 8'h66, 8'h46};
            7'h46: entry = '{KEY_CHAR, 8'h67, 8'h47};
            7'h47: entry = '{KEY_CHAR, 8'h68, 8'h48};
            7'h48: entry = '{KEY_CHAR, 8'h6A, 8'h4A};
            7'h49: entry = '{KEY_CHAR, 8'h6B, 8'h4B};
            7'h4A: entry = '{KEY_CHAR, 8'h6C, 8'h4C};
            7'h4B: entry = '{KEY_CHAR, 8'h3B, 8'h2B};
            7'h4C: entry = '{KEY_CHAR, 8'h3A, 8'h2A};
            7'h4D: entry = '{KEY_CHAR, 8'h5D, 8'h7D};
            7'h52: entry = '{KEY_CHAR, 8'h7A, 8'h5A};
            7'h53: entry = '{KEY_CHAR, 8'h78, 8'h58};
            7'h54: entry = '{KEY_CHAR, 8'h63, 8'h43};
            7'h55: entry = '{KEY_CHAR, 8'h76, 8'h56};
            7'h56: entry = '{KEY_CHAR, 8'h62, 8'h42};
            7'h57: entry = '{KEY_CHAR, 8'h6E, 8'h4E};
            7'h58: entry = '{KEY_CHAR, 8'h6D, 8'h4D};
            7'h59: entry = '{KEY_CHAR, 8'h2C, 8'h3C};
            7'h5A: entry = '{KEY_CHAR, 8'h2E, 8'h3E};
            7'h5B: entry = '{KEY_CHAR, 8'h2F, 8'h3F};
            7'h5C: entry = '{KEY_CHAR, 8'h5F, 8'h5F};
            default: entry = '{KEY_IGNORE, 8'h00, 8'h00};
        endcase
        return entry;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ksd_decode.sv =====
// Keymap lookup, modifier flag update and character formation for one scancode.
`default_nettype none

module ksd_decode
    import ksd_pkg::*;
(
    input  wire logic [SCANCODE_W-1:0] scancode,
    input  wire flags_t                flags_in,
    output flags_t                     flags_next,
    output result_t                    result
);

    key_entry_t        entry;
    logic              held;
    logic [CHAR_W-1:0] ch;

    assign entry = keymap_lookup(scancode[6:0]);
    assign held  = ~scancode[7];

    always_comb begin
        flags_next        = flags_in;
        ch                = '0;
        result.char_valid = 1'b0;
        result.kind       = KIND_OTHER;
        if (entry.key_type == KEY_MOD) begin
            case (entry.plain[1:0])
                MOD_SHIFT: flags_next.shift = held;
                MOD_CTRL:  flags_next.ctrl  = held;
                default:   flags_next.meta  = held;
            endcase
            result.kind = KIND_MOD;
        end else if (entry.key_type == KEY_CHAR && held) begin
            ch = flags_in.shift ? entry.upper : entry.plain;
            if (flags_in.meta) begin
                ch = ch | META_BIT;
            end
            if (flags_in.ctrl) begin
                ch = ch & CTRL_MASK;
            end
            result.char_valid = 1'b1;
            result.kind       = KIND_CHAR;
        end
        result.character = ch;
        result.flags     = flags_next;
    end

endmodule

`default_nettype wire

// ===== sv/keyboard_scancode_decoder.sv =====
// Top level of the keyboard scancode decoder: input register, decode, result register.
//
// Usage:
//   Slave channel s_* carries one raw scancode per transaction in s_tdata[7:0]
//   (bit 7 set for a key release). Master channel m_* returns one result per
//   scancode, in order. m_tdata holds the character, then the shift, ctrl and
//   meta flags as they stand after that scancode; m_tuser holds char_valid and
//   the event kind (character press, modifier event, other).
//   A scancode accepted into the input register moves into the result register
//   when the master side is free (m_tready high or the result register empty),
//   and its result is then offered on m_*.
//   Throughput: one scancode per cycle while the receiver takes results; the keymap ROM lookup and flag update
//   fit between the two registers.
//   Reset (aresetn low at a clock edge) empties both registers and clears the
//   three modifier flags.
//   When the receiver stalls, the result register holds; if the input register
//   is empty, one more scancode is taken into it, and after that s_tready drops
//   until the result is taken.
`default_nettype none

module keyboard_scancode_decoder
    import ksd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] scancode
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [7:0] character, [8] shift_held,
                                               // [9] ctrl_held, [10] meta_held
    output logic [TUSER_W-1:0]      m_tuser    // [0] char_valid, [2:1] kind
);

    logic                  in_valid_reg;
    logic [SCANCODE_W-1:0] scancode_reg;
    logic                  out_valid_reg;
    result_t               result_reg;
    flags_t                flags_reg;
    flags_t                flags_next;
    result_t               result_next;
    logic                  advance;
    logic                  fire;

    ksd_decode u_decode (
        .scancode   (scancode_reg),
        .flags_in   (flags_reg),
        .flags_next (flags_next),
        .result     (result_next)
    );

    assign advance  = ~out_valid_reg | m_tready;
    assign s_tready = ~in_valid_reg | advance;
    assign fire     = in_valid_reg & advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            scancode_reg <= s_tdata;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result_reg.flags.meta, result_reg.flags.ctrl,
                       result_reg.flags.shift, result_reg.character};
    assign m_tuser  = {result_reg.kind, result_reg.char_valid};

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the keyboard scancode decoder stream block.
`timescale 1ns / 100ps

module testbench;
    import ksd_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    localparam logic [6:0] SC_CTRL = 7'h0A;
    localparam logic [6:0] SC_SHIFT_L = 7'h0C;
    localparam logic [6:0] SC_SHIFT_R = 7'h0D;
    localparam logic [6:0] SC_META = 7'h0F;
    localparam logic [6:0] SC_TAB = 7'h09;
    localparam logic [6:0] SC_DEL = 7'h15;
    localparam logic [6:0] SC_ONE = 7'h22;
    localparam logic [6:0] SC_A = 7'h42;
    localparam logic [6:0] SC_UNDERSCORE = 7'h5C;
    localparam logic [6:0] SC_LAST = 7'h7F;
    localparam logic [6:0] SC_FIRST = 7'h00;

    typedef struct {
        logic [7:0] code;
        int         gap;
        bit         drain;
    } pending_key_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] character;
        logic [KIND_W-1:0] kind;
        logic              shift_held;
        logic              ctrl_held;
        logic              meta_held;
    } decoded_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;

    logic [1:0] keymap_type [128];
    logic [1:0] keymap_mod [128];
    logic [7:0] keymap_plain [128];
    logic [7:0] keymap_shifted [128];
    logic [6:0] char_keys [$];
    logic [6:0] mod_keys [$];

    logic shift_now, ctrl_now, meta_now;

    pending_key_t pending_keys [$];
    decoded_t expected_results [$];

    int scancodes_sent = 0;
    int results_taken = 0;
    int gap_left = 0;
    int stall_left = 0;
    int sink_calm = 0;
    int sender_calm = 0;
    int queued_count = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int chars_seen = 0;
    int mod_events = 0;
    bit drain_next = 1'b0;

    keyboard_scancode_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic map_char(input logic [6:0] key, input logic [7:0] plain,
                            input logic [7:0] shifted);
        keymap_type[key] = KEY_CHAR;
        keymap_plain[key] = plain;
        keymap_shifted[key] = shifted;
        char_keys.push_back(key);
    endtask

    task automatic map_mod(input logic [6:0] key, input logic [1:0] sel);
        keymap_type[key] = KEY_MOD;
        keymap_mod[key] = sel;
        mod_keys.push_back(key);
    endtask

    // Update the held flags and work out the result of one scancode.
    function automatic decoded_t decode_scancode(input logic [7:0] code);
        decoded_t r;
        logic pressed;
        logic [6:0] key;
        pressed = ~code[7];
        key = code[6:0];
        r = '0;
        r.kind = KIND_OTHER;
        if (keymap_type[key] == KEY_MOD) begin
            case (keymap_mod[key])
                MOD_SHIFT: shift_now = pressed;
                MOD_CTRL:  ctrl_now = pressed;
                default:   meta_now = pressed;
            endcase
            r.kind = KIND_MOD;
        end else if (keymap_type[key] == KEY_CHAR && pressed) begin
            r.character = shift_now ? keymap_shifted[key] : keymap_plain[key];
            if (meta_now) r.character = r.character | META_BIT;
            if (ctrl_now) r.character = r.character & CTRL_MASK;
            r.char_valid = 1'b1;
            r.kind = KIND_CHAR;
        end
        r.shift_held = shift_now;
        r.ctrl_held = ctrl_now;
        r.meta_held = meta_now;
        return r;
    endfunction

    task automatic queue_code(input logic [7:0] code);
        pending_key_t item;
        item.code = code;
        item.drain = drain_next;
        drain_next = 1'b0;
        if (sender_calm > 0) begin
            item.gap = 0;
            sender_calm--;
        end else begin
            if ($urandom_range(0, 49) == 0) sender_calm = $urandom_range(20, 60);
            item.gap = pick_gap();
        end
        pending_keys.push_back(item);
        queued_count++;
    endtask

    task automatic key_down(input logic [6:0] key);
        queue_code({1'b0, key});
    endtask

    task automatic key_up(input logic [6:0] key);
        queue_code({1'b1, key});
    endtask

    task automatic note_mismatch(input string what, input decoded_t want,
                                 input decoded_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t: %s: expected valid=%0b char=%02h kind=%0d s/c/m=%0b%0b%0b,",
                      " got valid=%0b char=%02h kind=%0d s/c/m=%0b%0b%0b"},
                     $realtime, what, want.char_valid, want.character, want.kind,
                     want.shift_held, want.ctrl_held, want.meta_held,
                     got.char_valid, got.character, got.kind,
                     got.shift_held, got.ctrl_held, got.meta_held);
    endtask

    // Driver: present queued scancodes, honoring gaps and drain points.
    always @(posedge aclk) begin
        pending_key_t item;
        int sent_now;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            gap_left <= 0;
        end else if (!(s_tvalid && !s_tready)) begin
            sent_now = scancodes_sent + (s_tvalid ? 1 : 0);
            if (s_tvalid) scancodes_sent <= sent_now;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_keys.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_keys[0].drain && sent_now != results_taken) begin
                s_tvalid <= 1'b0;
            end else begin
                item = pending_keys.pop_front();
                s_tdata <= item.code;
                s_tvalid <= 1'b1;
                gap_left <= item.gap;
            end
        end
    end

    // Monitor: predict on input transactions, check result transactions, stall the sink.
    always @(posedge aclk) begin
        decoded_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
            sink_calm <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(decode_scancode(s_tdata));
            if (m_tvalid && m_tready) begin
                results_taken <= results_taken + 1;
                got.char_valid = m_tuser[0];
                got.kind = m_tuser[2:1];
                got.character = m_tdata[7:0];
                got.shift_held = m_tdata[8];
                got.ctrl_held = m_tdata[9];
                got.meta_held = m_tdata[10];
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) note_mismatch("wrong result", want, got);
                    if (want.char_valid) chars_seen++;
                    if (want.kind == KIND_MOD) mod_events++;
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                if (sink_calm > 0)
                    sink_calm <= sink_calm - 1;
                else if ($urandom_range(0, 299) == 0)
                    sink_calm <= $urandom_range(50, 200);
                else
                    stall_left <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("keyboard_scancode_decoder: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int roll;
        logic [2:0] mods;
        logic [6:0] key;
        logic [6:0] shift_key;
        logic [6:0] other_shift;
        bit up;

        for (int i = 0; i < 128; i++) begin
            keymap_type[i] = KEY_IGNORE;
            keymap_mod[i] = MOD_SHIFT;
            keymap_plain[i] = 8'h00;
            keymap_shifted[i] = 8'h00;
        end
        map_mod(SC_CTRL, MOD_CTRL);
        map_mod(SC_SHIFT_L, MOD_SHIFT);
        map_mod(SC_SHIFT_R, MOD_SHIFT);
        map_mod(SC_META, MOD_META);
        map_char(7'h09, 8'h09, 8'h09); map_char(7'h10, 8'h1B, 8'h1B);
        map_char(7'h11, 8'h08, 8'h08); map_char(7'h12, 8'h0D, 8'h0D);
        map_char(7'h14, 8'h20, 8'h20); map_char(7'h15, 8'h7F, 8'h7F);
        map_char(7'h22, 8'h31, 8'h21); map_char(7'h23, 8'h32, 8'h22);
        map_char(7'h24, 8'h33, 8'h23); map_char(7'h25, 8'h34, 8'h24);
        map_char(7'h26, 8'h35, 8'h25); map_char(7'h27, 8'h36, 8'h26);
        map_char(7'h28, 8'h37, 8'h27); map_char(7'h29, 8'h38, 8'h28);
        map_char(7'h2A, 8'h39, 8'h29); map_char(7'h2B, 8'h30, 8'h30);
        map_char(7'h2C, 8'h2D, 8'h3D); map_char(7'h2D, 8'h5E, 8'h7E);
        map_char(7'h2E, 8'h5C, 8'h7C); map_char(7'h32, 8'h71, 8'h51);
        map_char(7'h33, 8'h77, 8'h57); map_char(7'h34, 8'h65, 8'h45);
        map_char(7'h35, 8'h72, 8'h52); map_char(7'h36, 8'h74, 8'h54);
        map_char(7'h37, 8'h79, 8'h59); map_char(7'h38, 8'h75, 8'h55);
        map_char(7'h39, 8'h69, 8'h49); map_char(7'h3A, 8'h6F, 8'h4F);
        map_char(7'h3B, 8'h70, 8'h50); map_char(7'h3C, 8'h40, 8'h60);
        map_char(7'h3D, 8'h5B, 8'h7B); map_char(7'h42, 8'h61, 8'h41);
        map_char(7'h43, 8'h73, 8'h53); map_char(7'h44, 8'h64, 8'h44);
        map_char(7'h45, 8'h66, 8'h46); map_char(7'h46, 8'h67, 8'h47);
        map_char(7'h47, 8'h68, 8'h48); map_char(7'h48, 8'h6A, 8'h4A);
        map_char(7'h49, 8'h6B, 8'h4B); map_char(7'h4A, 8'h6C, 8'h4C);
        map_char(7'h4B, 8'h3B, 8'h2B); map_char(7'h4C, 8'h3A, 8'h2A);
        map_char(7'h4D, 8'h5D, 8'h7D); map_char(7'h52, 8'h7A, 8'h5A);
        map_char(7'h53, 8'h78, 8'h58); map_char(7'h54, 8'h63, 8'h43);
        map_char(7'h55, 8'h76, 8'h56); map_char(7'h56, 8'h62, 8'h42);
        map_char(7'h57, 8'h6E, 8'h4E); map_char(7'h58, 8'h6D, 8'h4D);
        map_char(7'h59, 8'h2C, 8'h3C); map_char(7'h5A, 8'h2E, 8'h3E);
        map_char(7'h5B, 8'h2F, 8'h3F); map_char(7'h5C, 8'h5F, 8'h5F);
        shift_now = 1'b0;
        ctrl_now = 1'b0;
        meta_now = 1'b0;

        // Directed: code extremes, releases, each modifier, stacked modifiers.
        key_down(SC_FIRST);
        key_up(SC_LAST);
        key_down(SC_LAST);
        key_up(SC_FIRST);
        key_down(SC_ONE);
        key_up(SC_ONE);
        key_down(SC_SHIFT_L);
        key_down(SC_ONE);
        key_up(SC_SHIFT_R);
        key_up(SC_SHIFT_L);
        key_down(SC_META);
        key_down(SC_A);
        key_down(SC_CTRL);
        key_down(SC_A);
        key_down(SC_SHIFT_R);
        key_down(SC_DEL);
        key_down(SC_SHIFT_R);
        key_down(SC_TAB);
        key_up(SC_META);
        key_up(SC_CTRL);
        key_up(SC_SHIFT_R);
        key_down(SC_A);
        key_down(SC_A);
        key_down(SC_UNDERSCORE);
        drain_next = 1'b1;

        // Random: mostly modifier-wrapped typing, some noise and unbalanced modifiers.
        while (queued_count < 420) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
            if (roll < 70) begin
                mods = 3'($urandom_range(0, 7));
                shift_key = $urandom_range(0, 1) ? SC_SHIFT_L : SC_SHIFT_R;
                other_shift = SC_SHIFT_L ^ SC_SHIFT_R ^ shift_key;
                if (mods[0]) key_down(shift_key);
                if (mods[1]) key_down(SC_CTRL);
                if (mods[2]) key_down(SC_META);
                repeat ($urandom_range(1, 4)) begin
                    key = char_keys[$urandom_range(0, char_keys.size() - 1)];
                    key_down(key);
                    if ($urandom_range(0, 1)) key_up(key);
                end
                if (mods[2]) key_up(SC_META);
                if (mods[1]) key_up(SC_CTRL);
                if (mods[0]) key_up($urandom_range(0, 3) == 0 ? other_shift : shift_key);
            end else if (roll < 85) begin
                queue_code(8'($urandom_range(0, 255)));
            end else begin
                up = 1'($urandom_range(0, 1));
                key = mod_keys[$urandom_range(0, mod_keys.size() - 1)];
                if (up) key_up(key);
                else key_down(key);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_keys.size() != 0 || s_tvalid || scancodes_sent != results_taken)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (expected_results.size() != 0) begin
            mismatches += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("Sent %0d scancodes, checked %0d results (%0d characters, %0d modifier events).",
                 scancodes_sent, results_taken, chars_seen, mod_events);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("keyboard_scancode_decoder: match");
        end else begin
            $display("keyboard_scancode_decoder: mismatch");
        end
        $finish;
    end

endmodule
